// ===== sv/lir_pkg.sv =====
// ----------------------------------------------------------------------------
// Linear interpolator package
// Beat types and the side tag that travels with each item down the pipeline.
// ----------------------------------------------------------------------------
package lir_pkg;

    localparam int CoordMaxW = 32;
    localparam int ResultW   = 32;

    typedef struct packed {
        logic signed [CoordMaxW-1:0] x_query;
        logic signed [CoordMaxW-1:0] x_start;
        logic signed [CoordMaxW-1:0] x_end;
        logic signed [CoordMaxW-1:0] y_start;
        logic signed [CoordMaxW-1:0] y_end;
    } lir_item_t;

    typedef struct packed {
        logic signed [ResultW-1:0] y_value;
        logic                      clipped;
    } lir_result_t;

    typedef struct packed {
        logic neg;
        logic spec;
    } lir_tag_t;

endpackage

// ===== sv/lir_front.sv =====
// ----------------------------------------------------------------------------
// Linear interpolator front end
// Four stages: differences, products, numerator sum, and magnitudes with sign.
// ----------------------------------------------------------------------------
module lir_front #(
    parameter int W  = 16,
    parameter int QW = 2 * W + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_valid,
    input  logic signed [W-1:0]    x_query,
    input  logic signed [W-1:0]    x_start,
    input  logic signed [W-1:0]    x_end,
    input  logic signed [W-1:0]    y_start,
    input  logic signed [W-1:0]    y_end,
    output logic                   out_valid,
    output lir_pkg::lir_tag_t      out_tag,
    output logic [QW-1:0]          num_mag,
    output logic [W-1:0]           den_mag,
    output logic [W-1:0]           spec_val
);
    import lir_pkg::*;

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;

    logic signed [W:0]    dy1_reg, dy1_next;
    logic signed [W:0]    dxq1_reg, dxq1_next;
    logic signed [W:0]    den1_reg, den1_next;
    logic signed [W-1:0]  ys1_reg;
    logic                 spec1_reg, spec1_next;
    logic [W-1:0]         sv1_reg, sv1_next;

    logic signed [QW:0]   p1_2_reg, p1_2_next;
    logic signed [QW:0]   p2_2_reg, p2_2_next;
    logic signed [W:0]    den2_reg;
    logic                 spec2_reg;
    logic [W-1:0]         sv2_reg;

    logic signed [QW:0]   num3_reg, num3_next;
    logic signed [W:0]    den3_reg;
    logic                 spec3_reg;
    logic [W-1:0]         sv3_reg;

    logic [QW-1:0]        an4_reg, an4_next;
    logic [W-1:0]         ad4_reg, ad4_next;
    lir_tag_t             tag4_reg, tag4_next;
    logic [W-1:0]         sv4_reg;

    logic                 pick_start;
    logic signed [QW:0]   num_neg;
    logic signed [W:0]    den_neg;

    always_comb
    begin
        dy1_next   = $signed({y_end[W-1], y_end}) - $signed({y_start[W-1], y_start});
        dxq1_next  = $signed({x_query[W-1], x_query}) - $signed({x_start[W-1], x_start});
        den1_next  = $signed({x_end[W-1], x_end}) - $signed({x_start[W-1], x_start});
        pick_start = (x_start == x_end) || (y_start == y_end) || (x_query == x_start);
        spec1_next = pick_start || (x_query == x_end);
        sv1_next   = pick_start ? y_start : y_end;
    end

    always_comb
    begin
        p1_2_next = (QW+1)'(dy1_reg) * (QW+1)'(dxq1_reg);
        p2_2_next = (QW+1)'(ys1_reg) * (QW+1)'(den1_reg);
        num3_next = p1_2_reg + p2_2_reg;
    end

    always_comb
    begin
        num_neg       = -num3_reg;
        den_neg       = -den3_reg;
        an4_next      = num3_reg[QW] ? num_neg[QW-1:0] : num3_reg[QW-1:0];
        ad4_next      = den3_reg[W] ? den_neg[W-1:0] : den3_reg[W-1:0];
        tag4_next.neg  = num3_reg[QW] ^ den3_reg[W];
        tag4_next.spec = spec3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dy1_reg   <= dy1_next;
            dxq1_reg  <= dxq1_next;
            den1_reg  <= den1_next;
            ys1_reg   <= y_start;
            spec1_reg <= spec1_next;
            sv1_reg   <= sv1_next;

            p1_2_reg  <= p1_2_next;
            p2_2_reg  <= p2_2_next;
            den2_reg  <= den1_reg;
            spec2_reg <= spec1_reg;
            sv2_reg   <= sv1_reg;

            num3_reg  <= num3_next;
            den3_reg  <= den2_reg;
            spec3_reg <= spec2_reg;
            sv3_reg   <= sv2_reg;

            an4_reg   <= an4_next;
            ad4_reg   <= ad4_next;
            tag4_reg  <= tag4_next;
            sv4_reg   <= sv3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_tag   = tag4_reg;
    assign num_mag   = an4_reg;
    assign den_mag   = ad4_reg;
    assign spec_val  = sv4_reg;

endmodule

// ===== sv/lir_div_cell.sv =====
// ----------------------------------------------------------------------------
// Linear interpolator divider cell
// One restoring step: retires one quotient bit and hands the rest onward.
// ----------------------------------------------------------------------------
module lir_div_cell #(
    parameter int W  = 16,
    parameter int QW = 2 * W + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_valid,
    input  lir_pkg::lir_tag_t      in_tag,
    input  logic [W-1:0]           in_sv,
    input  logic [W-1:0]           in_den,
    input  logic [W-1:0]           in_rem,
    input  logic [QW-1:0]          in_num,
    input  logic [QW-1:0]          in_quo,
    output logic                   out_valid,
    output lir_pkg::lir_tag_t      out_tag,
    output logic [W-1:0]           out_sv,
    output logic [W-1:0]           out_den,
    output logic [W-1:0]           out_rem,
    output logic [QW-1:0]          out_num,
    output logic [QW-1:0]          out_quo
);
    import lir_pkg::*;

    logic              valid_reg;
    lir_tag_t          tag_reg;
    logic [W-1:0]      sv_reg;
    logic [W-1:0]      den_reg;
    logic [W-1:0]      rem_reg, rem_next;
    logic [QW-1:0]     num_reg, num_next;
    logic [QW-1:0]     quo_reg, quo_next;

    logic [W:0]        trial;
    logic [W:0]        diff;
    logic              take;

    always_comb
    begin
        trial    = {in_rem, in_num[QW-1]};
        diff     = trial - {1'b0, in_den};
        take     = trial >= {1'b0, in_den};
        rem_next = take ? diff[W-1:0] : trial[W-1:0];
        num_next = {in_num[QW-2:0], 1'b0};
        quo_next = {in_quo[QW-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag_reg <= in_tag;
            sv_reg  <= in_sv;
            den_reg <= in_den;
            rem_reg <= rem_next;
            num_reg <= num_next;
            quo_reg <= quo_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tag   = tag_reg;
    assign out_sv    = sv_reg;
    assign out_den   = den_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_quo   = quo_reg;

endmodule

// ===== sv/lir_back.sv =====
// ----------------------------------------------------------------------------
// Linear interpolator back end
// Rounds the quotient half away from zero, then applies sign and saturation.
// ----------------------------------------------------------------------------
module lir_back #(
    parameter int W  = 16,
    parameter int QW = 2 * W + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_valid,
    input  lir_pkg::lir_tag_t      in_tag,
    input  logic [W-1:0]           in_sv,
    input  logic [W-1:0]           in_den,
    input  logic [W-1:0]           in_rem,
    input  logic [QW-1:0]          in_quo,
    output logic                   out_valid,
    output lir_pkg::lir_result_t   out_result
);
    import lir_pkg::*;

    localparam int SW = (QW + 1 > ResultW + 1) ? QW + 1 : ResultW + 1;
    localparam logic [SW-1:0] LimPos = SW'(32'h7FFF_FFFF);
    localparam logic [SW-1:0] LimNeg = SW'(32'h8000_0000);

    logic              v1_reg, v2_reg;
    logic [QW:0]       qr_reg, qr_next;
    lir_tag_t          tag1_reg;
    logic [W-1:0]      sv1_reg;
    lir_result_t       res_reg, res_next;

    logic              round_up;
    logic [SW-1:0]     qx;

    always_comb
    begin
        round_up = {in_rem, 1'b0} >= {1'b0, in_den};
        qr_next  = {1'b0, in_quo} + {{QW{1'b0}}, round_up};
    end

    always_comb
    begin
        qx       = SW'(qr_reg);
        res_next = '0;
        if (tag1_reg.spec)
        begin
            res_next.y_value = {{(ResultW - W){sv1_reg[W-1]}}, sv1_reg};
            res_next.clipped = 1'b0;
        end
        else if (tag1_reg.neg)
        begin
            if (qx > LimNeg)
            begin
                res_next.y_value = 32'sh8000_0000;
                res_next.clipped = 1'b1;
            end
            else
            begin
                res_next.y_value = -qx[ResultW-1:0];
                res_next.clipped = 1'b0;
            end
        end
        else
        begin
            if (qx > LimPos)
            begin
                res_next.y_value = 32'sh7FFF_FFFF;
                res_next.clipped = 1'b1;
            end
            else
            begin
                res_next.y_value = qx[ResultW-1:0];
                res_next.clipped = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qr_reg   <= qr_next;
            tag1_reg <= in_tag;
            sv1_reg  <= in_sv;
            res_reg  <= res_next;
        end
    end

    assign out_valid  = v2_reg;
    assign out_result = res_reg;

endmodule

// ===== sv/linear_interpolate_rounded_unit.sv =====
// ----------------------------------------------------------------------------
// Linear interpolation unit, rounded to nearest
// Returns the value at x_query of the line through two points, saturated.
// ----------------------------------------------------------------------------
// The unit accepts one beat per clock while item_stall is low and returns one
// result beat for each, in order. Each beat passes through four front stages
// (differences, products, sum, magnitudes), the divider, a chain of
// 2*COORD_WIDTH + 1 cells that each retire one quotient bit, and two back
// stages (rounding, saturation). The whole pipeline holds while a result
// beat is stalled, so item_stall follows result_stall whenever the output
// register is full. Only the low COORD_WIDTH bits of each input field are
// used.
module linear_interpolate_rounded_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  lir_pkg::lir_item_t     item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output lir_pkg::lir_result_t   result
);
    import lir_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int QW = 2 * W + 1;

    logic              adv;

    logic              cv [0:QW];
    lir_tag_t          ct [0:QW];
    logic [W-1:0]      csv [0:QW];
    logic [W-1:0]      cden [0:QW];
    logic [W-1:0]      crem [0:QW];
    logic [QW-1:0]     cnum [0:QW];
    logic [QW-1:0]     cquo [0:QW];

    assign adv        = !result_valid || !result_stall;
    assign item_stall = !adv;

    lir_front #(
        .W  (W),
        .QW (QW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (item_valid),
        .x_query   (item.x_query[W-1:0]),
        .x_start   (item.x_start[W-1:0]),
        .x_end     (item.x_end[W-1:0]),
        .y_start   (item.y_start[W-1:0]),
        .y_end     (item.y_end[W-1:0]),
        .out_valid (cv[0]),
        .out_tag   (ct[0]),
        .num_mag   (cnum[0]),
        .den_mag   (cden[0]),
        .spec_val  (csv[0])
    );

    assign crem[0] = '0;
    assign cquo[0] = '0;

    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        lir_div_cell #(
            .W  (W),
            .QW (QW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (cv[i]),
            .in_tag    (ct[i]),
            .in_sv     (csv[i]),
            .in_den    (cden[i]),
            .in_rem    (crem[i]),
            .in_num    (cnum[i]),
            .in_quo    (cquo[i]),
            .out_valid (cv[i+1]),
            .out_tag   (ct[i+1]),
            .out_sv    (csv[i+1]),
            .out_den   (cden[i+1]),
            .out_rem   (crem[i+1]),
            .out_num   (cnum[i+1]),
            .out_quo   (cquo[i+1])
        );
    end

    lir_back #(
        .W  (W),
        .QW (QW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (cv[QW]),
        .in_tag     (ct[QW]),
        .in_sv      (csv[QW]),
        .in_den     (cden[QW]),
        .in_rem     (crem[QW]),
        .in_quo     (cquo[QW]),
        .out_valid  (result_valid),
        .out_result (result)
    );

endmodule
